[hw/rtl/shared_region_slot_table_defines.svh]
// assertion macros shared by the slot table modules
`ifndef SHARED_REGION_SLOT_TABLE_DEFINES_SVH
`define SHARED_REGION_SLOT_TABLE_DEFINES_SVH

`ifndef ASSERT_OFF
`define SRST_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("srst assertion failed");
`define SRST_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("srst assertion failed");
`else
`define SRST_ASSERT(lbl, clk, rst_n, prop)
`define SRST_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

[hw/rtl/srst_pkg.sv]
// types and constants of the shared region slot table
`default_nettype none

package srst_pkg;

    localparam int SLOT_COUNT_DEF = 16;

    localparam int ADDR_W     = 64;
    localparam int PE_W       = 12;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 2;
    localparam int SLOT_OUT_W = 4;

    localparam int S_TDATA_W = 144;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 72;
    localparam int M_TUSER_W = 2;

    localparam logic [OP_W-1:0] OP_REGISTER  = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE      = 2'd1;
    localparam logic [OP_W-1:0] OP_TRANSLATE = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE      = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REJECT   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic latch;
        logic idx_clr;
        logic idx_inc;
        logic found_clr;
        logic found_set;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic fast;
        logic match;
        logic last;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

[hw/rtl/shared_region_slot_table.sv]
// top level of the shared region slot table
//
//  channel   dir  handshake                word
//  s         in   i_s_tvalid/o_s_tready    tuser op, tdata address/size/pe
//  m         out  o_m_tvalid/i_m_tready    tuser status, tdata slot/hit/addr
//  cfg       in   i_cfg_valid/o_cfg_ready  local pe number
//
// one word at a time: accept, decide, then a scan of the slot memory with a
// registered read, then a compare, per slot, then finish
// fast cases (bad register, local translate, unused op) skip the scan
// a full scan reads every slot in turn through the single memory read port
// reset clears all slot valid bits at once, no clearing pass
// a stalled result waits in the output register; the next word is then taken
// and processed up to the finish step
`default_nettype none

module shared_region_slot_table #(
    parameter int SLOT_COUNT = srst_pkg::SLOT_COUNT_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [srst_pkg::PE_W-1:0]      i_cfg_data,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    // address, region_size, target_pe, zero pad
    input  wire logic [srst_pkg::S_TDATA_W-1:0] i_s_tdata,
    // operation
    input  wire logic [srst_pkg::S_TUSER_W-1:0] i_s_tuser,
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    // slot_index, local_hit, result_address, zero pad
    output logic [srst_pkg::M_TDATA_W-1:0]      o_m_tdata,
    // status
    output logic [srst_pkg::M_TUSER_W-1:0]      o_m_tuser
);
    import srst_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    assign o_cfg_ready = i_rst_n;

    srst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    srst_dpath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

endmodule

`default_nettype wire

[hw/rtl/srst_ctrl.sv]
// sequencer of the slot table: accept, decide, scan, finish
`default_nettype none
`include "shared_region_slot_table_defines.svh"

module srst_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    input  wire srst_pkg::t_stat i_stat,
    output srst_pkg::t_cmd     o_cmd
);
    import srst_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECIDE = 5'b00010,
        S_RD     = 5'b00100,
        S_CMP    = 5'b01000,
        S_FIN    = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = i_rst_n;
                if (i_s_tvalid && i_rst_n) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.found_clr = 1'b1;
                o_cmd.idx_clr   = 1'b1;
                n_state         = i_stat.fast ? S_FIN : S_RD;
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                priority if (i_stat.match) begin
                    o_cmd.found_set = 1'b1;
                    n_state         = S_FIN;
                end else if (i_stat.last) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_RD;
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `SRST_ASSERT(a_busy_after_accept, i_clk, i_rst_n, (i_s_tvalid && o_s_tready) |=> !o_s_tready)
    `SRST_ASSERT(a_fin_holds, i_clk, i_rst_n, (r_state == S_FIN && !i_stat.out_free) |=> (r_state == S_FIN))

endmodule

`default_nettype wire

[hw/rtl/srst_dpath.sv]
// slot memory, scan compare, result build and output register
`default_nettype none
`include "shared_region_slot_table_defines.svh"

module srst_dpath #(
    parameter int SLOT_COUNT = srst_pkg::SLOT_COUNT_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire srst_pkg::t_cmd               i_cmd,
    output srst_pkg::t_stat                   o_stat,
    input  wire logic                         i_cfg_valid,
    input  wire logic [srst_pkg::PE_W-1:0]    i_cfg_data,
    input  wire logic [srst_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  wire logic [srst_pkg::S_TUSER_W-1:0] i_s_tuser,
    output logic                              o_m_tvalid,
    input  wire logic                         i_m_tready,
    output logic [srst_pkg::M_TDATA_W-1:0]    o_m_tdata,
    output logic [srst_pkg::M_TUSER_W-1:0]    o_m_tuser
);
    import srst_pkg::*;

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IW-1:0] IDX_LAST = IW'(SLOT_COUNT - 1);

    logic [ADDR_W-1:0] mem_start [SLOT_COUNT];
    logic [ADDR_W-1:0] mem_len   [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_valid;

    logic [PE_W-1:0]   r_local_pe;
    logic [OP_W-1:0]   r_op;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] r_size;
    logic [PE_W-1:0]   r_tpe;
    logic [IW-1:0]     r_idx;
    logic              r_found;
    logic [ADDR_W-1:0] r_rd_start;
    logic [ADDR_W-1:0] r_rd_len;
    logic              r_rd_used;

    logic                  r_out_valid;
    logic [STATUS_W-1:0]   r_out_status;
    logic [SLOT_OUT_W-1:0] r_out_slot;
    logic                  r_out_hit;
    logic [ADDR_W-1:0]     r_out_addr;

    logic                  w_reject;
    logic                  w_local;
    logic [ADDR_W:0]       w_diff;
    logic                  w_in_range;
    logic                  w_we_reg;
    logic                  w_we_free;
    logic [STATUS_W-1:0]   w_status;
    logic [SLOT_OUT_W-1:0] w_slot;
    logic                  w_hit;
    logic [ADDR_W-1:0]     w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_pe <= '0;
        end else if (i_cfg_valid) begin
            r_local_pe <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op   <= i_s_tuser[OP_W-1:0];
            r_addr <= i_s_tdata[ADDR_W-1:0];
            r_size <= i_s_tdata[2*ADDR_W-1:ADDR_W];
            r_tpe  <= i_s_tdata[2*ADDR_W+PE_W-1:2*ADDR_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_found <= 1'b0;
        end else begin
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.found_clr) begin
                r_found <= 1'b0;
            end else if (i_cmd.found_set) begin
                r_found <= 1'b1;
            end
        end
    end

    // slot memory: one write port, one registered read port at the scan index
    always_ff @(posedge i_clk) begin
        if (w_we_reg) begin
            mem_start[r_idx] <= r_addr;
            mem_len[r_idx]   <= r_size;
        end
        r_rd_start <= mem_start[r_idx];
        r_rd_len   <= mem_len[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_rd_used <= 1'b0;
        end else begin
            if (w_we_reg) begin
                r_valid[r_idx] <= 1'b1;
            end else if (w_we_free) begin
                r_valid[r_idx] <= 1'b0;
            end
            r_rd_used <= r_valid[r_idx];
        end
    end

    assign w_reject   = (r_size == '0) || (r_addr == '0);
    assign w_local    = (r_tpe == r_local_pe);
    assign w_diff     = {1'b0, r_addr} - {1'b0, r_rd_start};
    assign w_in_range = r_rd_used && !w_diff[ADDR_W] && (w_diff[ADDR_W-1:0] < r_rd_len);

    assign o_stat.fast     = (r_op == OP_NONE) || ((r_op == OP_REGISTER) && w_reject) ||
                             ((r_op == OP_TRANSLATE) && w_local);
    assign o_stat.match    = (r_op == OP_REGISTER) ? !r_rd_used : w_in_range;
    assign o_stat.last     = (r_idx == IDX_LAST);
    assign o_stat.out_free = !r_out_valid || i_m_tready;

    assign w_we_reg  = i_cmd.finish && (r_op == OP_REGISTER) && !w_reject && r_found;
    assign w_we_free = i_cmd.finish && (r_op == OP_FREE) && r_found;

    always_comb begin
        w_status = ST_NOTFOUND;
        w_slot   = '0;
        w_hit    = 1'b0;
        w_res    = '0;
        unique case (r_op)
            OP_REGISTER: begin
                priority if (w_reject) begin
                    w_status = ST_REJECT;
                end else if (r_found) begin
                    w_status = ST_OK;
                    w_slot   = SLOT_OUT_W'(r_idx);
                    w_res    = r_addr;
                end else begin
                    w_status = ST_FULL;
                end
            end
            OP_FREE: begin
                if (r_found) begin
                    w_status = ST_OK;
                    w_slot   = SLOT_OUT_W'(r_idx);
                end
            end
            OP_TRANSLATE: begin
                priority if (w_local) begin
                    w_status = ST_OK;
                    w_hit    = 1'b1;
                    w_res    = r_addr;
                end else if (r_found) begin
                    w_status = ST_OK;
                    w_slot   = SLOT_OUT_W'(r_idx);
                    w_res    = w_diff[ADDR_W-1:0];
                end
            end
            OP_NONE: begin
                w_status = ST_NOTFOUND;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_status <= w_status;
            r_out_slot   <= w_slot;
            r_out_hit    <= w_hit;
            r_out_addr   <= w_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = {{(M_TDATA_W - SLOT_OUT_W - 1 - ADDR_W){1'b0}},
                         r_out_addr, r_out_hit, r_out_slot};

    `SRST_ASSERT(a_reg_sets_valid, i_clk, i_rst_n, w_we_reg |=> r_valid[$past(r_idx)])
    `SRST_ASSERT(a_free_clears_valid, i_clk, i_rst_n, w_we_free |=> !r_valid[$past(r_idx)])
    `SRST_ASSERT(a_hit_is_ok, i_clk, i_rst_n, (r_out_valid && r_out_hit) |-> (r_out_status == ST_OK))

endmodule

`default_nettype wire
